[hdl/stip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_pkg
// Types and constants shared by the sorted record table and its cells.
// ----------------------------------------------------------------------------
package stip_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 12;
  localparam int TAG_BITS    = 8;
  localparam int HANDLE_BITS = 8;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FIELD_CNT_W = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_PURGE  = 2'd1,
    FUNC_DUMP   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_ENTRY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PURGE,
    S_DUMP
  } state_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_PURGE,
    CM_ROTATE
  } cell_mode_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
  } rec_t;

  typedef struct packed {
    cell_mode_e          mode;
    logic [TAG_BITS-1:0] purge_tag;
    rec_t                new_rec;
  } cell_ctl_t;

  typedef struct packed {
    func_e                  func;
    logic [KEY_BITS-1:0]    sort_key;
    logic [TAG_BITS-1:0]    tag_code;
    logic [HANDLE_BITS-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic                   entry_valid;
    logic [KEY_BITS-1:0]    out_key;
    logic [TAG_BITS-1:0]    out_tag;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [FIELD_CNT_W-1:0] removed_count;
    logic [FIELD_CNT_W-1:0] occupancy;
    logic                   last;
  } res_t;

endpackage

[hdl/stip_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_cell
// One table slot: holds a record, compares it with the incoming key or the
// purge tag and takes its own, the new, the left or the right record.
// ----------------------------------------------------------------------------
module stip_cell (
  input  logic               clk_i,
  input  stip_pkg::cell_ctl_t ctl_i,
  input  logic               in_range_i,  // slot lies below the fill count
  input  logic               is_first_i,
  input  stip_pkg::rec_t     left_i,
  input  stip_pkg::rec_t     right_i,
  input  logic               after_i,     // left neighbour lies at/after insert point
  input  logic               hit_i,       // a purge match exists further left
  output stip_pkg::rec_t     rec_o,
  output logic               after_o,
  output logic               hit_o
);

  stip_pkg::rec_t rec_q, rec_d;
  logic           lt, tie, match;

  // equal key in the first slot keeps that slot in front of the new record
  assign lt      = in_range_i && (rec_q.key < ctl_i.new_rec.key);
  assign tie     = is_first_i && in_range_i && (rec_q.key == ctl_i.new_rec.key);
  assign after_o = !(lt || tie);

  assign match = in_range_i && (rec_q.tag == ctl_i.purge_tag);
  assign hit_o = hit_i || match;

  always_comb begin
    rec_d = rec_q;
    case (ctl_i.mode)
      stip_pkg::CM_INSERT: begin
        if (after_o) begin
          rec_d = after_i ? left_i : ctl_i.new_rec;
        end
      end
      stip_pkg::CM_PURGE: begin
        // first match and everything behind it close up by one slot
        if (hit_o) begin
          rec_d = right_i;
        end
      end
      stip_pkg::CM_ROTATE: begin
        rec_d = right_i;
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

[hdl/sorted_table_insert_and_purge_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_and_purge_top
// Sorted record table built as a row of slot cells: insert, purge by tag
// and in-order dump.
// ----------------------------------------------------------------------------
// Channel   | Ports                       | Transfer
// request   | start, req_i, busy          | start high and busy low at clk edge
// result    | strobe, res_o               | every cycle strobe is high
// config    | cfg_we_i, cfg_wdata_i       | cfg_we_i high at clk edge
//
// Insert: all cells compare and shift at once; result next cycle.
// Purge: a cell row closes one gap a cycle until no slot matches the purge tag.
// Dump: the row rotates once through all slots (an empty table answers without it).
// Reset clears the fill count and the purge tag; slot contents stay unknown.
// Results cannot be held off; busy is high during purge and dump.
// ----------------------------------------------------------------------------
module sorted_table_insert_and_purge_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  stip_pkg::req_t                   req_i,
  output logic                             busy,
  output logic                             strobe,
  output stip_pkg::res_t                   res_o,
  input  logic                             cfg_we_i,
  input  logic [stip_pkg::TAG_BITS-1:0]    cfg_wdata_i
);

  stip_pkg::state_e                 state_q, state_d;
  logic [stip_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [stip_pkg::CNT_W-1:0]       removed_q, removed_d;
  logic [stip_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [stip_pkg::TAG_BITS-1:0]    purge_tag_q;
  stip_pkg::res_t                   res_q, res_d;
  logic                             strobe_q, strobe_d;

  stip_pkg::cell_ctl_t              ctl;
  stip_pkg::rec_t                   rec   [stip_pkg::TABLE_DEPTH];
  logic                             after [stip_pkg::TABLE_DEPTH];
  logic                             hit   [stip_pkg::TABLE_DEPTH];
  logic                             accept, full, hit_any, dump_last;

  assign accept  = start && (state_q == stip_pkg::S_IDLE);
  assign full    = (cnt_q == stip_pkg::CNT_W'(stip_pkg::TABLE_DEPTH));
  assign hit_any = hit[stip_pkg::TABLE_DEPTH-1];
  assign dump_last = ((stip_pkg::CNT_W'(idx_q) + stip_pkg::CNT_W'(1)) == cnt_q);

  // cell row
  always_comb begin
    ctl.purge_tag       = purge_tag_q;
    ctl.new_rec.key     = req_i.sort_key;
    ctl.new_rec.tag     = req_i.tag_code;
    ctl.new_rec.handle  = req_i.handle;
    ctl.mode            = stip_pkg::CM_HOLD;
    unique case (state_q)
      stip_pkg::S_PURGE: ctl.mode = stip_pkg::CM_PURGE;
      stip_pkg::S_DUMP:  ctl.mode = stip_pkg::CM_ROTATE;
      default: begin
        if (accept && (req_i.func == stip_pkg::FUNC_INSERT) && !full) begin
          ctl.mode = stip_pkg::CM_INSERT;
        end
      end
    endcase
  end

  for (genvar i = 0; i < stip_pkg::TABLE_DEPTH; i++) begin : g_cell
    stip_pkg::rec_t left_rec, right_rec;
    logic           after_in, hit_in;
    if (i == 0) begin : g_head
      assign left_rec = rec[0];
      assign after_in = 1'b0;
      assign hit_in   = 1'b0;
    end else begin : g_body
      assign left_rec = rec[i-1];
      assign after_in = after[i-1];
      assign hit_in   = hit[i-1];
    end
    // last slot takes the head record so a dump rotates the row
    assign right_rec = (i == stip_pkg::TABLE_DEPTH - 1) ? rec[0] :
                       rec[(i + 1) % stip_pkg::TABLE_DEPTH];

    stip_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .in_range_i (stip_pkg::CNT_W'(i) < cnt_q),
      .is_first_i (i == 0),
      .left_i     (left_rec),
      .right_i    (right_rec),
      .after_i    (after_in),
      .hit_i      (hit_in),
      .rec_o      (rec[i]),
      .after_o    (after[i]),
      .hit_o      (hit[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stip_pkg::S_IDLE: begin
        if (accept && (req_i.func == stip_pkg::FUNC_PURGE)) begin
          state_d = stip_pkg::S_PURGE;
        end else if (accept && (req_i.func == stip_pkg::FUNC_DUMP) &&
                     (cnt_q != '0)) begin
          state_d = stip_pkg::S_DUMP;
        end
      end
      stip_pkg::S_PURGE: begin
        if (!hit_any) state_d = stip_pkg::S_IDLE;
      end
      stip_pkg::S_DUMP: begin
        if (idx_q == stip_pkg::IDX_W'(stip_pkg::TABLE_DEPTH - 1)) state_d = stip_pkg::S_IDLE;
      end
      default: state_d = stip_pkg::S_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cnt_d     = cnt_q;
    removed_d = removed_q;
    idx_d     = idx_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    res_d.status    = stip_pkg::STATUS_DONE;
    res_d.occupancy = stip_pkg::FIELD_CNT_W'(cnt_q);
    res_d.last      = 1'b1;
    unique case (state_q)
      stip_pkg::S_IDLE: begin
        removed_d = '0;
        idx_d     = '0;
        if (accept) begin
          unique case (req_i.func)
            stip_pkg::FUNC_INSERT: begin
              strobe_d = 1'b1;
              if (full) begin
                res_d.status = stip_pkg::STATUS_FULL;
              end else begin
                cnt_d           = cnt_q + stip_pkg::CNT_W'(1);
                res_d.occupancy = stip_pkg::FIELD_CNT_W'(cnt_d);
              end
            end
            stip_pkg::FUNC_PURGE: strobe_d = 1'b0;
            stip_pkg::FUNC_DUMP: begin
              if (cnt_q == '0) begin
                strobe_d     = 1'b1;
                res_d.status = stip_pkg::STATUS_ENTRY;
              end
            end
            default: strobe_d = 1'b1;
          endcase
        end
      end
      stip_pkg::S_PURGE: begin
        if (hit_any) begin
          cnt_d     = cnt_q - stip_pkg::CNT_W'(1);
          removed_d = removed_q + stip_pkg::CNT_W'(1);
        end else begin
          strobe_d            = 1'b1;
          res_d.removed_count = stip_pkg::FIELD_CNT_W'(removed_q);
        end
      end
      stip_pkg::S_DUMP: begin
        idx_d = idx_q + stip_pkg::IDX_W'(1);
        if (stip_pkg::CNT_W'(idx_q) < cnt_q) begin
          strobe_d          = 1'b1;
          res_d.status      = stip_pkg::STATUS_ENTRY;
          res_d.entry_valid = 1'b1;
          res_d.out_key     = rec[0].key;
          res_d.out_tag     = rec[0].tag;
          res_d.out_handle  = rec[0].handle;
          res_d.last        = dump_last;
        end
      end
      default: strobe_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stip_pkg::S_IDLE;
      cnt_q       <= '0;
      removed_q   <= '0;
      idx_q       <= '0;
      purge_tag_q <= '0;
      strobe_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      removed_q <= removed_d;
      idx_q     <= idx_d;
      strobe_q  <= strobe_d;
      if (cfg_we_i) purge_tag_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy   = (state_q != stip_pkg::S_IDLE);
  assign strobe = strobe_q;
  assign res_o  = res_q;

endmodule
